// ===== design/lba_to_chs_track_splitter_defines.svh =====
// Assertion macros shared by the track splitter RTL.
// Each macro expects signals named clock and reset in the including scope.
`ifndef LBA_TO_CHS_TRACK_SPLITTER_DEFINES_SVH
`define LBA_TO_CHS_TRACK_SPLITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lcts_pkg.sv =====
// Shared types, constants and geometry helpers for the LBA to CHS track splitter.
// Used by the controller, the datapath and the top level.
`default_nettype none

package lcts_pkg;

   localparam int unsigned LbaWidth     = 32;
   localparam int unsigned PagesWidth   = 3;
   localparam int unsigned SptWidth     = 6;
   localparam int unsigned HeadsWidth   = 9;
   localparam int unsigned CylWidth     = 10;
   localparam int unsigned HeadWidth    = 8;
   localparam int unsigned CountWidth   = 6;
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 40;
   localparam int unsigned CsrAddrWidth = 3;

   localparam logic [SptWidth-1:0]   SptReset   = 6'd63;
   localparam logic [HeadsWidth-1:0] HeadsReset = 9'd16;
   localparam logic [HeadsWidth-1:0] HeadsMax   = 9'd256;

   // Register index as selected by address bit 2.
   localparam logic RegSpt   = 1'b0;
   localparam logic RegHeads = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START1 = 7'b0000010,
      ST_WAIT1  = 7'b0000100,
      ST_START2 = 7'b0001000,
      ST_WAIT2  = 7'b0010000,
      ST_SETUP  = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } lcts_state_type;

   typedef struct packed {
      logic load_req;
      logic div_start;
      logic div_second;
      logic capture_sector;
      logic setup;
      logic emit;
   } lcts_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic next_last;
      logic out_free;
   } lcts_status_type;

   function automatic logic [SptWidth-1:0] eff_spt(input logic [SptWidth-1:0] spt);
      eff_spt = (spt == '0) ? SptWidth'(1) : spt;
   endfunction

   function automatic logic [HeadsWidth-1:0] eff_heads(input logic [HeadsWidth-1:0] heads);
      priority if (heads == '0) begin
         eff_heads = HeadsWidth'(1);
      end else if (heads > HeadsMax) begin
         eff_heads = HeadsMax;
      end else begin
         eff_heads = heads;
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/lba_to_chs_track_splitter.sv =====
// Top level of the LBA to CHS track splitter: register port, controller and datapath.
// Depends on lcts_pkg, lcts_ctrl, lcts_datapath and the assertion macro header.
//
// A request carries a starting logical sector and a page count of eight sectors each.
// The block converts the sector to cylinder, head and sector with the configured
// geometry and emits one read command per track touched; a page count of zero gives
// one command with a sector count of zero. Both conversions run through one shared
// restoring divider at one quotient bit per cycle; once both are done, the block emits one
// command per cycle while the output is taken, at most 56 commands per request. One
// request is handled at a time; the next one is accepted as soon as the last command is
// in the output register. Cylinder numbers carry only their low ten bits. The user must
// write geometry through the register port only while no request is in flight; the
// block itself does not enforce this.
`include "lba_to_chs_track_splitter_defines.svh"
`default_nettype none

module lba_to_chs_track_splitter
   import lcts_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // req_tdata: start_lba [31:0], page_count [34:32], zero [39:35]
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   // rsp_tdata: cylinder [9:0], head [17:10], start_sector [23:18],
   //            sector_count [29:24], buffer_offset [35:30], zero [39:36]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataWidth-1:0]      rsp_tdata,
   output logic                         rsp_tlast,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [SptWidth-1:0]   spt_ff, spt_in;
   logic [HeadsWidth-1:0] heads_ff, heads_in;
   logic                  csr_write;

   lcts_cmd_type          cmd;
   lcts_status_type       status;

   logic [CylWidth-1:0]   rsp_cylinder;
   logic [HeadWidth-1:0]  rsp_head;
   logic [SptWidth-1:0]   rsp_start_sector;
   logic [CountWidth-1:0] rsp_sector_count;
   logic [CountWidth-1:0] rsp_buffer_offset;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      spt_in   = spt_ff;
      heads_in = heads_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            RegSpt:   spt_in   = csr_pwdata[SptWidth-1:0];
            RegHeads: heads_in = csr_pwdata[HeadsWidth-1:0];
            default:  spt_in   = spt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff   <= SptReset;
         heads_ff <= HeadsReset;
      end else begin
         spt_ff   <= spt_in;
         heads_ff <= heads_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == RegHeads) ? {23'd0, heads_ff} : {26'd0, spt_ff};

   lcts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lcts_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_lba           (req_tdata[LbaWidth-1:0]),
      .req_pages         (req_tdata[LbaWidth+PagesWidth-1:LbaWidth]),
      .spt_eff           (eff_spt(spt_ff)),
      .heads_eff         (eff_heads(heads_ff)),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_cylinder      (rsp_cylinder),
      .rsp_head          (rsp_head),
      .rsp_start_sector  (rsp_start_sector),
      .rsp_sector_count  (rsp_sector_count),
      .rsp_buffer_offset (rsp_buffer_offset),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_buffer_offset, rsp_sector_count, rsp_start_sector,
                       rsp_head, rsp_cylinder};

   // A request keeps the block busy for at least the two divisions.
   `LCTS_ASSERT_NEXT(a_busy_after_request, req_tvalid && req_tready, !req_tready,
      "request accepted while the previous one is still in flight")

   // Every command stays inside the eight-sector pages of the request.
   `LCTS_ASSERT_NOW(a_offset_in_buffer, rsp_tvalid,
      ({1'b0, rsp_buffer_offset} + {1'b0, rsp_sector_count}) <= 7'd56,
      "command reaches past the end of the request buffer")

   // Only the final command of a request may carry zero sectors.
   `LCTS_ASSERT_NOW(a_empty_only_last, rsp_tvalid && !rsp_tlast,
      rsp_sector_count != 6'd0,
      "empty command that is not the last of its request")

endmodule

`default_nettype wire

// ===== design/lcts_divider.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 9-bit divisor.
// Depends on lcts_pkg for widths.
`default_nettype none

module lcts_divider
   import lcts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [LbaWidth-1:0]   dividend,
   input  wire logic [HeadsWidth-1:0] divisor,
   output logic                       busy,
   output logic [LbaWidth-1:0]        quotient,
   output logic [HeadsWidth-1:0]      remainder
);

   logic                  busy_ff, busy_in;
   logic [4:0]            count_ff, count_in;
   logic [LbaWidth-1:0]   quo_ff, quo_in;
   logic [HeadsWidth-1:0] rem_ff, rem_in;
   logic [HeadsWidth-1:0] div_ff, div_in;
   logic [HeadsWidth:0]   rem_sh;
   logic [HeadsWidth:0]   rem_sub;
   logic                  ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[LbaWidth-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[LbaWidth-2:0], ge};
         rem_in   = ge ? rem_sub[HeadsWidth-1:0] : rem_sh[HeadsWidth-1:0];
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/lcts_datapath.sv =====
// Datapath: request capture, the shared divider, track position and output register.
// Depends on lcts_pkg and lcts_divider.
`default_nettype none

module lcts_datapath
   import lcts_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lcts_cmd_type            cmd,
   output lcts_status_type              status,
   input  wire logic [LbaWidth-1:0]     req_lba,
   input  wire logic [PagesWidth-1:0]   req_pages,
   input  wire logic [SptWidth-1:0]     spt_eff,
   input  wire logic [HeadsWidth-1:0]   heads_eff,
   input  wire logic                    rsp_tready,
   output logic                         rsp_tvalid,
   output logic [CylWidth-1:0]          rsp_cylinder,
   output logic [HeadWidth-1:0]         rsp_head,
   output logic [SptWidth-1:0]          rsp_start_sector,
   output logic [CountWidth-1:0]        rsp_sector_count,
   output logic [CountWidth-1:0]        rsp_buffer_offset,
   output logic                         rsp_last
);

   logic [LbaWidth-1:0]   lba_ff, lba_in;
   logic [PagesWidth-1:0] pages_ff, pages_in;
   logic [CylWidth-1:0]   cyl_ff, cyl_in;
   logic [HeadWidth-1:0]  head_ff, head_in;
   logic [SptWidth-1:0]   sector_ff, sector_in;
   logic [CountWidth-1:0] remaining_ff, remaining_in;
   logic [CountWidth-1:0] offset_ff, offset_in;
   logic [SptWidth-1:0]   chunk_ff, chunk_in;

   logic                  valid_ff, valid_in;
   logic [CylWidth-1:0]   o_cyl_ff, o_cyl_in;
   logic [HeadWidth-1:0]  o_head_ff, o_head_in;
   logic [SptWidth-1:0]   o_sector_ff, o_sector_in;
   logic [CountWidth-1:0] o_count_ff, o_count_in;
   logic [CountWidth-1:0] o_offset_ff, o_offset_in;
   logic                  o_last_ff, o_last_in;

   logic                  div_busy;
   logic [LbaWidth-1:0]   div_quo;
   logic [HeadsWidth-1:0] div_rem;
   logic [LbaWidth-1:0]   div_dividend;
   logic [HeadsWidth-1:0] div_divisor;

   logic                  last_now;
   logic [CountWidth-1:0] count_now;
   logic [HeadsWidth-1:0] head_next;

   // The second division reuses the quotient of the first, still held in the divider.
   assign div_dividend = cmd.div_second ? div_quo : lba_ff;
   assign div_divisor  = cmd.div_second ? heads_eff : {3'b000, spt_eff};

   lcts_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign last_now  = chunk_ff >= remaining_ff;
   assign count_now = last_now ? remaining_ff : chunk_ff;
   assign head_next = {1'b0, head_ff} + HeadsWidth'(1);

   always_comb begin
      lba_in       = lba_ff;
      pages_in     = pages_ff;
      cyl_in       = cyl_ff;
      head_in      = head_ff;
      sector_in    = sector_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      chunk_in     = chunk_ff;
      o_cyl_in     = o_cyl_ff;
      o_head_in    = o_head_ff;
      o_sector_in  = o_sector_ff;
      o_count_in   = o_count_ff;
      o_offset_in  = o_offset_ff;
      o_last_in    = o_last_ff;
      valid_in     = rsp_tready ? 1'b0 : valid_ff;

      if (cmd.load_req) begin
         lba_in   = req_lba;
         pages_in = req_pages;
      end
      if (cmd.capture_sector) begin
         sector_in = div_rem[SptWidth-1:0] + SptWidth'(1);
      end
      if (cmd.setup) begin
         head_in      = div_rem[HeadWidth-1:0];
         cyl_in       = div_quo[CylWidth-1:0];
         remaining_in = {pages_ff, 3'b000};
         offset_in    = '0;
         chunk_in     = spt_eff - sector_ff + SptWidth'(1);
      end
      if (cmd.emit) begin
         valid_in     = 1'b1;
         o_cyl_in     = cyl_ff;
         o_head_in    = head_ff;
         o_sector_in  = sector_ff;
         o_count_in   = count_now;
         o_offset_in  = offset_ff;
         o_last_in    = last_now;
         offset_in    = offset_ff + count_now;
         remaining_in = remaining_ff - count_now;
         chunk_in     = spt_eff;
         sector_in    = SptWidth'(1);
         if (head_next >= heads_eff) begin
            head_in = '0;
            cyl_in  = cyl_ff + CylWidth'(1);
         end else begin
            head_in = head_next[HeadWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lba_ff       <= lba_in;
      pages_ff     <= pages_in;
      cyl_ff       <= cyl_in;
      head_ff      <= head_in;
      sector_ff    <= sector_in;
      remaining_ff <= remaining_in;
      offset_ff    <= offset_in;
      chunk_ff     <= chunk_in;
      o_cyl_ff     <= o_cyl_in;
      o_head_ff    <= o_head_in;
      o_sector_ff  <= o_sector_in;
      o_count_ff   <= o_count_in;
      o_offset_ff  <= o_offset_in;
      o_last_ff    <= o_last_in;
   end

   assign status.div_busy  = div_busy;
   assign status.next_last = last_now;
   assign status.out_free  = !valid_ff || rsp_tready;

   assign rsp_tvalid        = valid_ff;
   assign rsp_cylinder      = o_cyl_ff;
   assign rsp_head          = o_head_ff;
   assign rsp_start_sector  = o_sector_ff;
   assign rsp_sector_count  = o_count_ff;
   assign rsp_buffer_offset = o_offset_ff;
   assign rsp_last          = o_last_ff;

endmodule

`default_nettype wire

// ===== design/lcts_ctrl.sv =====
// Controller state machine: sequences the two divisions and the command emission.
// Depends on lcts_pkg for the state and command types.
`default_nettype none

module lcts_ctrl
   import lcts_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire lcts_status_type status,
   output lcts_cmd_type         cmd
);

   lcts_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_START1;
            end
         end
         ST_START1: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (!status.div_busy) begin
               state_in = ST_START2;
            end
         end
         ST_START2: begin
            cmd.div_start      = 1'b1;
            cmd.div_second     = 1'b1;
            cmd.capture_sector = 1'b1;
            state_in           = ST_WAIT2;
         end
         ST_WAIT2: begin
            if (!status.div_busy) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.next_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire
